@@ rtl/core/box_overlap_test_2d_top_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef BOX_OVERLAP_TEST_2D_TOP_DEFINES_SVH
`define BOX_OVERLAP_TEST_2D_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define BOT2D_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define BOT2D_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bot2d_pkg.sv @@
`timescale 1ns / 1ps

package bot2d_pkg;

    localparam int COORD_W  = 32;
    localparam int AXIS_W   = 16;
    localparam int AXIS_F   = AXIS_W - 2;
    localparam int SIZE_W   = COORD_W - 1;
    localparam int SLACK_W  = 8;
    localparam logic [SLACK_W-1:0] SLACK_RST = SLACK_W'(1);

    localparam int NSTG     = 6;

    // derived datapath widths
    localparam int RP_W     = 2 * AXIS_W;           // axis x axis product
    localparam int R_W      = RP_W + 1;             // rotation term
    localparam int AR_W     = R_W;                  // |R| + slack
    localparam int N_W      = 2 * AXIS_W;           // squared length of A axis
    localparam int TP_W     = COORD_W + AXIS_W;     // coord x axis product
    localparam int T_W      = TP_W + 1;             // projection
    localparam int M_W      = T_W - 1;              // projection magnitude
    localparam int LO_W     = M_W / 2;
    localparam int HI_W     = M_W - LO_W;
    localparam int P_W      = SIZE_W + AR_W;        // size x |R|
    localparam int CMP_W    = COORD_W + 3 * AXIS_W + 1;

    // stream word layout
    localparam int OFS_DX   = 0;
    localparam int OFS_DY   = OFS_DX + COORD_W;
    localparam int OFS_SAX  = OFS_DY + COORD_W;
    localparam int OFS_SAY  = OFS_SAX + SIZE_W;
    localparam int OFS_SBX  = OFS_SAY + SIZE_W;
    localparam int OFS_SBY  = OFS_SBX + SIZE_W;
    localparam int OFS_AAX  = OFS_SBY + SIZE_W;
    localparam int OFS_AAY  = OFS_AAX + AXIS_W;
    localparam int OFS_ABX  = OFS_AAY + AXIS_W;
    localparam int OFS_ABY  = OFS_ABX + AXIS_W;
    localparam int IN_BITS  = OFS_ABY + AXIS_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = 8;

    typedef enum logic {
        MODE_AABB = 1'b0,
        MODE_OBB  = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [COORD_W-1:0]  delta_x;
        logic [COORD_W-1:0]  delta_y;
        logic [SIZE_W-1:0]   size_a_x;
        logic [SIZE_W-1:0]   size_a_y;
        logic [SIZE_W-1:0]   size_b_x;
        logic [SIZE_W-1:0]   size_b_y;
        logic [AXIS_W-1:0]   axis_a_x;
        logic [AXIS_W-1:0]   axis_a_y;
        logic [AXIS_W-1:0]   axis_b_x;
        logic [AXIS_W-1:0]   axis_b_y;
    } t_in_word;

    typedef struct packed {
        logic [NSTG-1:0]     load;
        logic [SLACK_W-1:0]  slack;
    } t_pipe_ctl;

endpackage

@@ rtl/core/bot2d_sat_dp.sv @@
`timescale 1ns / 1ps

module bot2d_sat_dp
    import bot2d_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_in_word  i_in,
    output logic      o_overlap
);

    // --- stage 1: products, corner test
    logic signed [COORD_W-1:0] w_dx, w_dy;
    logic signed [AXIS_W-1:0]  w_ax, w_ay, w_bx, w_by;
    logic signed [COORD_W:0]   w_dx_e, w_dy_e, w_ea0_e, w_ea1_e, w_eb0_e, w_eb1_e;

    assign w_dx    = $signed(i_in.delta_x);
    assign w_dy    = $signed(i_in.delta_y);
    assign w_ax    = $signed(i_in.axis_a_x);
    assign w_ay    = $signed(i_in.axis_a_y);
    assign w_bx    = $signed(i_in.axis_b_x);
    assign w_by    = $signed(i_in.axis_b_y);
    assign w_dx_e  = $signed({w_dx[COORD_W-1], w_dx});
    assign w_dy_e  = $signed({w_dy[COORD_W-1], w_dy});
    assign w_ea0_e = $signed({2'b00, i_in.size_a_x});
    assign w_ea1_e = $signed({2'b00, i_in.size_a_y});
    assign w_eb0_e = $signed({2'b00, i_in.size_b_x});
    assign w_eb1_e = $signed({2'b00, i_in.size_b_y});

    logic signed [RP_W-1:0] r1_pc1, r1_pc2, r1_ps1, r1_ps2;
    logic [RP_W-1:0]        r1_pn1, r1_pn2;
    logic signed [TP_W-1:0] r1_pt1, r1_pt2, r1_pt3, r1_pt4;
    logic signed [TP_W-1:0] r1_pu1, r1_pu2, r1_pu3, r1_pu4;
    logic [SIZE_W-1:0]      r1_ea0, r1_ea1, r1_eb0, r1_eb1;
    t_mode                  r1_mode;
    logic                   r1_ov0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_pc1  <= w_ax * w_bx;
            r1_pc2  <= w_ay * w_by;
            r1_ps1  <= w_ay * w_bx;
            r1_ps2  <= w_ax * w_by;
            r1_pn1  <= w_ax * w_ax;
            r1_pn2  <= w_ay * w_ay;
            r1_pt1  <= w_dx * w_ax;
            r1_pt2  <= w_dy * w_ay;
            r1_pt3  <= w_dy * w_ax;
            r1_pt4  <= w_dx * w_ay;
            r1_pu1  <= w_dx * w_bx;
            r1_pu2  <= w_dy * w_by;
            r1_pu3  <= w_dy * w_bx;
            r1_pu4  <= w_dx * w_by;
            r1_ea0  <= i_in.size_a_x;
            r1_ea1  <= i_in.size_a_y;
            r1_eb0  <= i_in.size_b_x;
            r1_eb1  <= i_in.size_b_y;
            r1_mode <= i_in.mode;
            r1_ov0  <= (w_dx_e < w_eb0_e) && (w_dx_e > -w_ea0_e) &&
                       (w_dy_e < w_eb1_e) && (w_dy_e > -w_ea1_e);
        end
    end

    // --- stage 2: dot products
    // c = uA0.uB0 = uA1.uB1, s = uA0.uB1 = -uA1.uB0
    logic signed [R_W-1:0] r2_c, r2_s;
    logic [N_W-1:0]        r2_n;
    logic signed [T_W-1:0] r2_t0, r2_t1, r2_s0, r2_s1;
    logic [SIZE_W-1:0]     r2_ea0, r2_ea1, r2_eb0, r2_eb1;
    t_mode                 r2_mode;
    logic                  r2_ov0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_c    <= r1_pc1 + r1_pc2;
            r2_s    <= r1_ps1 - r1_ps2;
            r2_n    <= r1_pn1 + r1_pn2;
            r2_t0   <= r1_pt1 + r1_pt2;
            r2_t1   <= r1_pt3 - r1_pt4;
            r2_s0   <= r1_pu1 + r1_pu2;
            r2_s1   <= r1_pu3 - r1_pu4;
            r2_ea0  <= r1_ea0;
            r2_ea1  <= r1_ea1;
            r2_eb0  <= r1_eb0;
            r2_eb1  <= r1_eb1;
            r2_mode <= r1_mode;
            r2_ov0  <= r1_ov0;
        end
    end

    // --- stage 3: magnitudes, slack
    function automatic logic [M_W-1:0] f_mag_t(input logic [T_W-1:0] v);
        logic [T_W-1:0] inv;
        inv = v[T_W-1] ? ~v : v;
        return inv[M_W-1:0] + M_W'(v[T_W-1]);
    endfunction

    function automatic logic [AR_W-1:0] f_mag_r(input logic [R_W-1:0] v,
                                                input logic [SLACK_W-1:0] sl);
        logic [R_W-1:0] inv;
        inv = v[R_W-1] ? ~v : v;
        return AR_W'(inv) + AR_W'(v[R_W-1]) + AR_W'({sl, {AXIS_F{1'b0}}});
    endfunction

    logic [AR_W-1:0]   r3_arc, r3_ars;
    logic [N_W-1:0]    r3_n;
    logic [M_W-1:0]    r3_mt0, r3_mt1, r3_ms0, r3_ms1;
    logic [SIZE_W-1:0] r3_ea0, r3_ea1, r3_eb0, r3_eb1;
    t_mode             r3_mode;
    logic              r3_ov0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_arc  <= f_mag_r(r2_c, i_ctl.slack);
            r3_ars  <= f_mag_r(r2_s, i_ctl.slack);
            r3_n    <= r2_n;
            r3_mt0  <= f_mag_t(r2_t0);
            r3_mt1  <= f_mag_t(r2_t1);
            r3_ms0  <= f_mag_t(r2_s0);
            r3_ms1  <= f_mag_t(r2_s1);
            r3_ea0  <= r2_ea0;
            r3_ea1  <= r2_ea1;
            r3_eb0  <= r2_eb0;
            r3_eb1  <= r2_eb1;
            r3_mode <= r2_mode;
            r3_ov0  <= r2_ov0;
        end
    end

    // --- stage 4: extent products; |proj B_j| = |uA0|^2 * |d.uB_j|, split in halves
    logic [P_W-1:0]       r4_pa0, r4_pa1, r4_pa2, r4_pa3;
    logic [P_W-1:0]       r4_pb0, r4_pb1, r4_pb2, r4_pb3;
    logic [N_W+LO_W-1:0]  r4_ll0, r4_ll1;
    logic [N_W+HI_W-1:0]  r4_lh0, r4_lh1;
    logic [M_W-1:0]       r4_mt0, r4_mt1;
    logic [SIZE_W-1:0]    r4_ea0, r4_ea1, r4_eb0, r4_eb1;
    t_mode                r4_mode;
    logic                 r4_ov0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_pa0  <= r3_eb0 * r3_arc;
            r4_pa1  <= r3_eb1 * r3_ars;
            r4_pa2  <= r3_eb0 * r3_ars;
            r4_pa3  <= r3_eb1 * r3_arc;
            r4_pb0  <= r3_ea0 * r3_arc;
            r4_pb1  <= r3_ea1 * r3_ars;
            r4_pb2  <= r3_ea0 * r3_ars;
            r4_pb3  <= r3_ea1 * r3_arc;
            r4_ll0  <= r3_n * r3_ms0[LO_W-1:0];
            r4_lh0  <= r3_n * r3_ms0[M_W-1:LO_W];
            r4_ll1  <= r3_n * r3_ms1[LO_W-1:0];
            r4_lh1  <= r3_n * r3_ms1[M_W-1:LO_W];
            r4_mt0  <= r3_mt0;
            r4_mt1  <= r3_mt1;
            r4_ea0  <= r3_ea0;
            r4_ea1  <= r3_ea1;
            r4_eb0  <= r3_eb0;
            r4_eb1  <= r3_eb1;
            r4_mode <= r3_mode;
            r4_ov0  <= r3_ov0;
        end
    end

    // --- stage 5: both sides of the four axis tests
    logic [CMP_W-1:0] r5_la0, r5_la1, r5_ra0, r5_ra1;
    logic [CMP_W-1:0] r5_lb0, r5_lb1, r5_rb0, r5_rb1;
    t_mode            r5_mode;
    logic             r5_ov0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r5_la0  <= CMP_W'({r4_mt0, {AXIS_F{1'b0}}});
            r5_la1  <= CMP_W'({r4_mt1, {AXIS_F{1'b0}}});
            r5_ra0  <= CMP_W'({r4_ea0, {(2 * AXIS_F){1'b0}}}) +
                       CMP_W'(r4_pa0) + CMP_W'(r4_pa1);
            r5_ra1  <= CMP_W'({r4_ea1, {(2 * AXIS_F){1'b0}}}) +
                       CMP_W'(r4_pa2) + CMP_W'(r4_pa3);
            r5_lb0  <= (CMP_W'(r4_lh0) << LO_W) + CMP_W'(r4_ll0);
            r5_lb1  <= (CMP_W'(r4_lh1) << LO_W) + CMP_W'(r4_ll1);
            r5_rb0  <= ((CMP_W'(r4_pb0) + CMP_W'(r4_pb1)) << AXIS_F) +
                       CMP_W'({r4_eb0, {(3 * AXIS_F){1'b0}}});
            r5_rb1  <= ((CMP_W'(r4_pb2) + CMP_W'(r4_pb3)) << AXIS_F) +
                       CMP_W'({r4_eb1, {(3 * AXIS_F){1'b0}}});
            r5_mode <= r4_mode;
            r5_ov0  <= r4_ov0;
        end
    end

    // --- stage 6: compare, pick mode
    logic w_sep;
    assign w_sep = (r5_la0 > r5_ra0) || (r5_la1 > r5_ra1) ||
                   (r5_lb0 > r5_rb0) || (r5_lb1 > r5_rb1);

    logic r6_ov;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            unique case (r5_mode)
                MODE_OBB:  r6_ov <= !w_sep;
                MODE_AABB: r6_ov <= r5_ov0;
                default:   r6_ov <= r5_ov0;
            endcase
        end
    end

    assign o_overlap = r6_ov;

endmodule

@@ rtl/core/box_overlap_test_2d_top.sv @@
`timescale 1ns / 1ps

// Overlap test for one pair of 2D boxes per stream word: axis-aligned corner
// test (tuser = 0) or four-axis separating axis test on oriented boxes
// (tuser = 1), exact fixed point throughout. One pair is accepted every cycle
// while s_axis_tready is high and passes through six register stages, two of
// which hold the multiplier banks (axis and offset products, then extent
// products and the split wide projection product). Each stage has its own
// valid bit and ready, so a stall at the output only holds input back once
// every stage is occupied, and bubbles are squeezed out. abs_slack (reset 1)
// is set via i_cfg_we / i_cfg_wdata, applied at the magnitude stage, and must
// be written only while the pipeline is empty; the block does not enforce it.
module box_overlap_test_2d_top
    import bot2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [SLACK_W-1:0] i_cfg_wdata,    // abs_slack

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // delta_x, delta_y, size_a_x, size_a_y, size_b_x, size_b_y,
    // axis_a_x, axis_a_y, axis_b_x, axis_b_y, zero pad
    input  logic [IN_W-1:0]    s_axis_tdata,
    input  logic               s_axis_tuser,   // mode

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata    // overlap, zero pad
);

    `include "box_overlap_test_2d_top_defines.svh"

    logic [SLACK_W-1:0] r_slack;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG:0]      w_rdy;
    t_in_word           w_in;
    t_pipe_ctl          w_ctl;
    logic               w_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slack <= SLACK_RST;
        end else if (i_cfg_we) begin
            r_slack <= i_cfg_wdata;
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb begin
        w_rdy[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_in.mode     = t_mode'(s_axis_tuser);
    assign w_in.delta_x  = s_axis_tdata[OFS_DX  +: COORD_W];
    assign w_in.delta_y  = s_axis_tdata[OFS_DY  +: COORD_W];
    assign w_in.size_a_x = s_axis_tdata[OFS_SAX +: SIZE_W];
    assign w_in.size_a_y = s_axis_tdata[OFS_SAY +: SIZE_W];
    assign w_in.size_b_x = s_axis_tdata[OFS_SBX +: SIZE_W];
    assign w_in.size_b_y = s_axis_tdata[OFS_SBY +: SIZE_W];
    assign w_in.axis_a_x = s_axis_tdata[OFS_AAX +: AXIS_W];
    assign w_in.axis_a_y = s_axis_tdata[OFS_AAY +: AXIS_W];
    assign w_in.axis_b_x = s_axis_tdata[OFS_ABX +: AXIS_W];
    assign w_in.axis_b_y = s_axis_tdata[OFS_ABY +: AXIS_W];

    assign w_ctl.load  = w_rdy[NSTG-1:0];
    assign w_ctl.slack = r_slack;

    bot2d_sat_dp u_dp (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_in      (w_in),
        .o_overlap (w_ov)
    );

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, w_ov};

    `BOT2D_ASSERT_IMP(a_ready_drop_full, !s_axis_tready,
        (r_vld == {NSTG{1'b1}}) && !m_axis_tready, "input ready low with a free stage")
    `BOT2D_ASSERT_IMP(a_ready_follows_out, m_axis_tready, s_axis_tready,
        "input stalled while output drains")
    `BOT2D_ASSERT_NXT(a_no_extra_word,
        m_axis_tvalid && m_axis_tready && !r_vld[NSTG-2], !m_axis_tvalid,
        "output word appeared without a source")

endmodule
